// File: hw/rtl/bmr_pkg.sv
package bmr_pkg;

  // Fixed field widths
  localparam int DIV_W     = 64;  // dividend
  localparam int RES_W     = 32;  // remainder field
  localparam int MU_W      = 34;  // reciprocal mu
  localparam int HALF_W    = 32;  // split point of the quotient multiplier
  localparam int PROD_W    = 68;  // low product bits kept for the quotient estimate
  localparam int CFG_W     = 34;  // config write data, widest register
  localparam int CFG_IDX_W = 2;   // config register index

  // Config register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS = 2'd0,
    REG_MU      = 2'd1
  } cfg_reg_t;

  localparam logic [MU_W-1:0] MU_RESET = MU_W'(5);

endpackage

// File: hw/rtl/bmr_in_if.sv
interface bmr_in_if import bmr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIV_W-1:0] dividend;

  modport source (output valid, output dividend, input ready);
  modport sink   (input valid, input dividend, output ready);
endinterface

// File: hw/rtl/bmr_out_if.sv
interface bmr_out_if import bmr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] remainder;
  logic             out_of_range;

  modport source (output valid, output remainder, output out_of_range, input ready);
  modport sink   (input valid, input remainder, input out_of_range, output ready);
endinterface

// File: hw/rtl/bmr_cfg.sv
module bmr_cfg import bmr_pkg::*; #(
  parameter int MOD_BITS = 32,
  parameter int KW       = $clog2(MOD_BITS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output logic [MOD_BITS-1:0]  modulus,
  output logic [MU_W-1:0]      mu,
  output logic [KW-1:0]        k
);

  logic [MOD_BITS-1:0] modulus_r;
  logic [MU_W-1:0]     mu_r;
  logic [KW-1:0]       k_r;
  logic [KW-1:0]       k_nxt;

  // Bit length of the incoming modulus, captured with the write
  always_comb begin
    k_nxt = '0;
    for (int i = 0; i < MOD_BITS; i++) begin
      if (cfg_wdata[i]) k_nxt = KW'(i + 1);
    end
  end

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_BITS'(3);
      k_r       <= KW'(2);
      mu_r      <= MU_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_MODULUS: begin
          modulus_r <= cfg_wdata[MOD_BITS-1:0];
          k_r       <= k_nxt;
        end
        REG_MU: begin
          mu_r <= cfg_wdata[MU_W-1:0];
        end
        default: ;
      endcase
    end
  end

  assign modulus = modulus_r;
  assign mu      = mu_r;
  assign k       = k_r;

endmodule

// File: hw/rtl/bmr_qest.sv
module bmr_qest import bmr_pkg::*; #(
  parameter int MOD_BITS = 32,
  parameter int KW       = $clog2(MOD_BITS + 1),
  parameter int WW       = MOD_BITS + 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DIV_W-1:0] dividend,
  input  logic [MU_W-1:0]  mu,
  input  logic [KW-1:0]    k,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WW-1:0]    q,
  output logic [WW-1:0]    a_lo,
  output logic             flag
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  // Stage 1: pre-shift and range flag
  logic [DIV_W-1:0] ash_r;
  logic [WW-1:0]    alo1_r;
  logic             flag1_r;
  logic [KW-1:0]    k_m1;
  logic [KW:0]      k2;
  logic [DIV_W-1:0] hi_part;

  // Stage 2: partial products
  logic [2*HALF_W-1:0]      pp_ll_r, pp_hl_r;
  logic [HALF_W+1:0]        pp_lh_r, pp_hh_r;
  logic [WW-1:0]            alo2_r;
  logic                     flag2_r;
  logic [2*HALF_W-1:0]      ll_nxt, hl_nxt;
  logic [HALF_W+1:0]        lh_nxt, hh_nxt;

  // Stage 3: product sum
  logic [PROD_W-1:0] sum_r;
  logic [PROD_W-1:0] sum_nxt;
  logic [WW-1:0]     alo3_r;
  logic              flag3_r;

  // Stage 4: quotient estimate
  logic [WW-1:0]     q_r;
  logic [WW-1:0]     alo4_r;
  logic              flag4_r;
  logic [KW:0]       k_p1;
  logic [PROD_W-1:0] sh;

  // Stall chain: a stage advances when empty or when the next one advances
  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];

  // Stage 1 logic; zero modulus is reported as out of range
  assign k_m1    = k - KW'(1);
  assign k2      = {k, 1'b0};
  assign hi_part = dividend >> k2;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ash_r   <= dividend >> k_m1;
      alo1_r  <= dividend[WW-1:0];
      flag1_r <= (k == '0) || (|hi_part);
    end
  end

  // Stage 2 logic: 64 x 34 split into four pieces
  assign ll_nxt = {{HALF_W{1'b0}}, ash_r[HALF_W-1:0]} * {{HALF_W{1'b0}}, mu[HALF_W-1:0]};
  assign hl_nxt = {{HALF_W{1'b0}}, ash_r[DIV_W-1:HALF_W]} * {{HALF_W{1'b0}}, mu[HALF_W-1:0]};
  assign lh_nxt = {2'b00, ash_r[HALF_W-1:0]} * {{HALF_W{1'b0}}, mu[MU_W-1:HALF_W]};
  assign hh_nxt = {2'b00, ash_r[DIV_W-1:HALF_W]} * {{HALF_W{1'b0}}, mu[MU_W-1:HALF_W]};

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pp_ll_r <= ll_nxt;
      pp_hl_r <= hl_nxt;
      pp_lh_r <= lh_nxt;
      pp_hh_r <= hh_nxt;
      alo2_r  <= alo1_r;
      flag2_r <= flag1_r;
    end
  end

  // Stage 3 logic: recombine modulo 2^PROD_W
  assign sum_nxt = {{(PROD_W-2*HALF_W){1'b0}}, pp_ll_r}
                 + {pp_hl_r[PROD_W-HALF_W-1:0], {HALF_W{1'b0}}}
                 + {{(PROD_W-2*HALF_W-2){1'b0}}, pp_lh_r, {HALF_W{1'b0}}}
                 + {pp_hh_r[PROD_W-2*HALF_W-1:0], {(2*HALF_W){1'b0}}};

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      sum_r   <= sum_nxt;
      alo3_r  <= alo2_r;
      flag3_r <= flag2_r;
    end
  end

  // Stage 4 logic: drop k+1 bits
  assign k_p1 = {1'b0, k} + (KW+1)'(1);
  assign sh   = sum_r >> k_p1;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      q_r     <= sh[WW-1:0];
      alo4_r  <= alo3_r;
      flag4_r <= flag3_r;
    end
  end

  assign q    = q_r;
  assign a_lo = alo4_r;
  assign flag = flag4_r;

endmodule

// File: hw/rtl/bmr_corr.sv
module bmr_corr import bmr_pkg::*; #(
  parameter int MOD_BITS = 32,
  parameter int KW       = $clog2(MOD_BITS + 1),
  parameter int WW       = MOD_BITS + 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WW-1:0]       q,
  input  logic [WW-1:0]       a_lo,
  input  logic                flag,
  input  logic [MOD_BITS-1:0] modulus,
  input  logic [KW-1:0]       k,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RES_W-1:0]    remainder,
  output logic                out_of_range
);

  localparam int NS = 4;

  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  logic [WW-1:0]          n_ext;
  logic [WW-1:0]          qn_nxt;
  logic [WW-1:0]          qn_r, alo5_r;
  logic                   flag5_r;
  logic [WW-1:0]          mask;
  logic [KW+1:0]          k_p2;
  logic [WW-1:0]          r6_r, r7_r;
  logic                   flag6_r, flag7_r;
  logic [WW-1:0]          r6_sub, r7_sub;
  logic [RES_W+WW-1:0]    r_ext;
  logic [RES_W-1:0]       rem_r;
  logic                   oor_r;

  // Stall chain
  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v_r[NS-1];

  assign n_ext = {2'b00, modulus};

  // Stage 5: q * n, only the low WW bits are kept
  assign qn_nxt = q * n_ext;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      qn_r    <= qn_nxt;
      alo5_r  <= a_lo;
      flag5_r <= flag;
    end
  end

  // Stage 6: window difference mod 2^(k+2)
  assign k_p2 = {2'b00, k} + (KW+2)'(2);

  always_comb begin
    for (int i = 0; i < WW; i++) begin
      mask[i] = ((KW+2)'(i) < k_p2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      r6_r    <= (alo5_r - qn_r) & mask;
      flag6_r <= flag5_r;
    end
  end

  // Stage 7: first correction
  assign r6_sub = r6_r - n_ext;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      r7_r    <= (r6_r >= n_ext) ? r6_sub : r6_r;
      flag7_r <= flag6_r;
    end
  end

  // Stage 8: second correction, output register; zero modulus gives 0
  assign r7_sub = r7_r - n_ext;
  assign r_ext  = {{RES_W{1'b0}}, ((r7_r >= n_ext) ? r7_sub : r7_r)};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      rem_r <= (k == '0) ? '0 : r_ext[RES_W-1:0];
      oor_r <= flag7_r;
    end
  end

  assign remainder    = rem_r;
  assign out_of_range = oor_r;

endmodule

// File: hw/rtl/barrett_modular_reduction_unit.sv
// Channel  | Dir | Handshake    | Payload
// ---------+-----+--------------+--------------------------------------
// in_ch    | in  | valid/ready  | dividend[63:0]
// out_ch   | out | valid/ready  | remainder[31:0], out_of_range
// cfg_*    | in  | cfg_we only  | cfg_idx (0 modulus, 1 mu), cfg_wdata[33:0]
//
// One transaction per cycle sustained while out_ch is ready; eight register
// stages lie between the input channel and the output channel.
// The 64 x 34 quotient multiply is split at bit 32 into four partial products;
// the pre-shift, the products, their sum and the shift by k+1 are each a stage,
// then q*n, the window difference and two conditional subtracts, a stage each.
// Reset clears all valid bits and loads modulus 3, mu 5; no clearing pass.
// A stalled output only holds the stages behind it until a bubble is reached,
// so input stays ready while any stage is empty.
module barrett_modular_reduction_unit import bmr_pkg::*; #(
  parameter int MOD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bmr_in_if.sink               in_ch,
  bmr_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int KW = $clog2(MOD_BITS + 1);
  localparam int WW = MOD_BITS + 2;

  logic [MOD_BITS-1:0] modulus;
  logic [MU_W-1:0]     mu;
  logic [KW-1:0]       k;

  logic                mid_valid, mid_ready;
  logic [WW-1:0]       mid_q, mid_alo;
  logic                mid_flag;

  // Configuration registers
  bmr_cfg #(.MOD_BITS(MOD_BITS), .KW(KW)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .modulus   (modulus),
    .mu        (mu),
    .k         (k)
  );

  // Quotient estimate
  bmr_qest #(.MOD_BITS(MOD_BITS), .KW(KW), .WW(WW)) u_qest (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .dividend  (in_ch.dividend),
    .mu        (mu),
    .k         (k),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .q         (mid_q),
    .a_lo      (mid_alo),
    .flag      (mid_flag)
  );

  // Remainder and corrections
  bmr_corr #(.MOD_BITS(MOD_BITS), .KW(KW), .WW(WW)) u_corr (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mid_valid),
    .in_ready     (mid_ready),
    .q            (mid_q),
    .a_lo         (mid_alo),
    .flag         (mid_flag),
    .modulus      (modulus),
    .k            (k),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .remainder    (out_ch.remainder),
    .out_of_range (out_ch.out_of_range)
  );

  // An empty output stage lets the whole pipe move
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input not ready while output stage empty");

  // Zero modulus yields remainder 0 flagged out of range
  a_zero_modulus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (k == '0)) |-> (out_ch.out_of_range && (out_ch.remainder == '0)))
    else $error("zero modulus result wrong");

  // The boundary between the two halves never blocks when its sink is empty
  a_mid_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_valid && mid_ready && !in_ch.ready) |-> out_ch.valid)
    else $error("pipeline stalled with empty output stage");

endmodule

// File: bench/tb_barrett_modular_reduction_unit.sv
module tb_barrett_modular_reduction_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bmr_pkg::*;

  localparam int MOD_BITS = 32;
  localparam int LATENCY = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [RES_W-1:0] MOD_MASK = RES_W'((64'd1 << MOD_BITS) - 1);
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [RES_W-1:0] remainder;
    logic             out_of_range;
  } reduction_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  bmr_in_if  in_ch();
  bmr_out_if out_ch();

  barrett_modular_reduction_unit #(.MOD_BITS(MOD_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // local copy of the configuration registers
  logic [RES_W-1:0] cur_modulus;
  logic [MU_W-1:0]  cur_mu;

  reduction_t  expected_reductions[$];
  int unsigned error_count;
  int unsigned ready_stall_pct;
  int unsigned send_gap_pct;
  int unsigned hold_off_cycles;

  // clock, 8 ns period
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned modulus_bits(logic [RES_W-1:0] n);
    int unsigned len;
    len = 0;
    for (int i = 0; i < RES_W; i++) begin
      if (n[i]) len = i + 1;
    end
    return len;
  endfunction

  // Barrett datapath: quotient estimate, window difference, two corrections
  function automatic reduction_t predict_reduction(logic [DIV_W-1:0] a);
    reduction_t  res;
    int unsigned k;
    logic [97:0] product;
    logic [63:0] quot, diff, win_mask, n64;
    res.dividend = a;
    k = modulus_bits(cur_modulus);
    if (k == 0) begin
      res.remainder = '0;
      res.out_of_range = 1'b1;
      return res;
    end
    n64 = {32'b0, cur_modulus};
    res.out_of_range = (2 * k < 64) ? ((a >> (2 * k)) != 0) : 1'b0;
    product = {34'b0, a >> (k - 1)} * {64'b0, cur_mu};
    quot = 64'(product >> (k + 1));
    win_mask = (64'd1 << (k + 2)) - 1;
    diff = (a - quot * n64) & win_mask;
    if (diff >= n64) diff = diff - n64;
    if (diff >= n64) diff = diff - n64;
    res.remainder = diff[RES_W-1:0];
    return res;
  endfunction

  function automatic logic [MU_W-1:0] reciprocal_for(logic [RES_W-1:0] n);
    logic [64:0] num;
    num = 65'd1 << (2 * modulus_bits(n));
    return MU_W'(num / {33'b0, n});
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random modulus with a random bit length, never a power of two
  function automatic logic [RES_W-1:0] pick_modulus();
    int unsigned roll, k;
    logic [RES_W-1:0] n;
    roll = $urandom_range(0, 9);
    k = (roll == 0) ? 32 : (roll == 1) ? 2 : $urandom_range(2, 32);
    n = $urandom;
    if (k < 32) n = n & ((32'd1 << k) - 1);
    n[k-1] = 1'b1;
    if (n == (32'd1 << (k - 1))) n[0] = 1'b1;
    return n;
  endfunction

  // mostly below n*n, some small, some at the range edge, some noise
  function automatic logic [DIV_W-1:0] pick_dividend(logic [RES_W-1:0] n);
    logic [63:0] raw, square;
    int unsigned roll, k;
    raw = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    k = modulus_bits(n);
    if (n == 0) return raw;
    square = {32'b0, n} * {32'b0, n};
    if (roll < 65) return raw % square;
    if (roll < 80) return raw % ({32'b0, n} << 1);
    if (roll < 88) begin
      if (k == 32) return ~64'(raw[1:0]);
      return (64'd1 << (2 * k)) - 1 + 64'(raw[0]);
    end
    if (roll < 92) return square - 1 - 64'(raw[1:0]);
    return raw;
  endfunction

  // one register write; the model copy follows the same rules as the block
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS: cur_modulus = value[RES_W-1:0] & MOD_MASK;
      REG_MU:      cur_mu = value[MU_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [RES_W-1:0] n, logic [MU_W-1:0] mu);
    write_register(REG_MODULUS, CFG_W'(n));
    write_register(REG_MU, CFG_W'(mu));
  endtask

  // one input transaction; valid stays high when the next one follows at once
  task automatic send_dividend(logic [DIV_W-1:0] a);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.dividend <= a;
    do @(posedge clk); while (!in_ch.ready);
    expected_reductions.push_back(predict_reduction(a));
  endtask

  // sender idles until every result is back, then the pipeline settles
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_reductions.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // modulus 3, mu 5 straight out of reset
    send_dividend(64'd0);
    send_dividend(64'd1);
    send_dividend(64'd8);
    send_dividend(64'd15);
    send_dividend(64'd16);
    send_dividend('1);
    wait_drained();
  endtask

  task automatic test_full_width_modulus();
    logic [RES_W-1:0] n;
    n = '1;
    // bits above the modulus width are dropped on write
    write_register(REG_MODULUS, {2'b11, n});
    write_register(REG_MU, CFG_W'(reciprocal_for(n)));
    send_dividend(64'd0);
    send_dividend({32'b0, n - 1});
    send_dividend({32'b0, n});
    send_dividend({32'b0, n} * {32'b0, n} - 1);
    send_dividend('1);
    wait_drained();
  endtask

  task automatic test_power_of_two_modulus();
    configure(32'd2, 34'd8);
    send_dividend(64'd3);
    send_dividend(64'd15);
    wait_drained();
    configure(32'h8000_0000, 34'h2_0000_0000);
    send_dividend('1);
    send_dividend({$urandom, $urandom});
    wait_drained();
  endtask

  task automatic test_zero_modulus();
    write_register(REG_MODULUS, '0);
    send_dividend(64'd0);
    send_dividend('1);
    wait_drained();
  endtask

  task automatic test_wrong_mu();
    configure(32'h8000_0001, '0);
    send_dividend('1);
    send_dividend(64'h1234_5678_9ABC_DEF0);
    wait_drained();
    write_register(REG_MU, '1);
    send_dividend('1);
    send_dividend(64'h4000_0001_0000_0000);
    wait_drained();
  endtask

  task automatic test_unmapped_index();
    configure(32'd1000003, reciprocal_for(32'd1000003));
    write_register(REG_SPARE_A, '1);
    write_register(REG_SPARE_B, '0);
    send_dividend(64'd1000002 * 64'd1000003);
    send_dividend(64'd12345678901);
    wait_drained();
  endtask

  // random configurations, each with a stream of random dividends
  task automatic test_random_reductions(int unsigned phases, int unsigned per_phase);
    logic [RES_W-1:0] n;
    logic [MU_W-1:0]  mu;
    int unsigned      roll;
    for (int p = 0; p < phases; p++) begin
      n = pick_modulus();
      mu = reciprocal_for(n);
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        mu = MU_W'({$urandom, $urandom});
      end else if (roll < 15) begin
        n = 32'd1 << (modulus_bits(n) - 1);
        mu = reciprocal_for(n);
      end
      configure(n, mu);
      ready_stall_pct = (p % 3 == 0) ? 0 : $urandom_range(10, 50);
      send_gap_pct = (p % 4 == 1) ? 0 : $urandom_range(10, 50);
      for (int i = 0; i < per_phase; i++) send_dividend(pick_dividend(n));
      wait_drained();
    end
  endtask

  // receiver holds off while the sender streams, so the input backs up
  task automatic test_output_backpressure();
    logic [RES_W-1:0] n;
    n = pick_modulus();
    configure(n, reciprocal_for(n));
    ready_stall_pct = 0;
    send_gap_pct = 0;
    hold_off_cycles = 80;
    for (int i = 0; i < 40; i++) send_dividend(pick_dividend(n));
    wait_drained();
  endtask

  // result receiver: random stalls plus the long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if ($urandom_range(0, 99) < ready_stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // compare each result transaction with the oldest expected reduction
  always @(posedge clk) begin
    reduction_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reductions.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: remainder %h out_of_range %b",
                   out_ch.remainder, out_ch.out_of_range);
      end else begin
        exp_res = expected_reductions.pop_front();
        if (out_ch.remainder !== exp_res.remainder ||
            out_ch.out_of_range !== exp_res.out_of_range) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch a=%h n=%h mu=%h: exp %h/%b got %h/%b",
                     exp_res.dividend, cur_modulus, cur_mu, exp_res.remainder,
                     exp_res.out_of_range, out_ch.remainder, out_ch.out_of_range);
        end
      end
    end
  end

  // hang guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_MODULUS;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.dividend = '0;
    error_count = 0;
    hold_off_cycles = 0;
    ready_stall_pct = 30;
    send_gap_pct = 30;
    cur_modulus = 32'd3;
    cur_mu = MU_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_full_width_modulus();
    test_power_of_two_modulus();
    test_zero_modulus();
    test_wrong_mu();
    test_unmapped_index();
    test_output_backpressure();
    test_random_reductions(10, 48);

    repeat (LATENCY + 8) @(posedge clk);
    if (error_count == 0 && expected_reductions.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
